[hw/rtl/pcpn_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse-coupled phase network package
// Shared opcodes, datapath command and status types and saturation helper.
// ----------------------------------------------------------------------------
package pcpn_pkg;

    localparam logic [2:0] OP_LOAD_F1 = 3'd0;
    localparam logic [2:0] OP_LOAD_F2 = 3'd1;
    localparam logic [2:0] OP_LOAD_N  = 3'd2;
    localparam logic [2:0] OP_STEP    = 3'd3;
    localparam logic [2:0] OP_READ    = 3'd4;

    localparam logic KIND_SPIKE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic CRV_F1 = 1'b0;
    localparam logic CRV_F2 = 1'b1;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_DECODE,
        DP_RD_LAT,
        DP_RD_OUT,
        DP_F1Z_RD,
        DP_F1Z_LAT,
        DP_T_RD,
        DP_T_MUL,
        DP_T_MIN,
        DP_T_FIRE,
        DP_U_RD,
        DP_U_LAT,
        DP_U_FIRER,
        DP_U_P,
        DP_I_X,
        DP_I_LO,
        DP_I_HI,
        DP_I_MUL,
        DP_I_V,
        DP_I_K,
        DP_I_APPLY,
        DP_U_NEXT,
        DP_O_SCAN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   crv;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       out_free;
        logic       n_last;
        logic       fire_n;
        logic       div_done;
    } t_dp_sts;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] res;
        if (v > 72'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -72'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/pcpn_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pcpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/pcpn_div.sv]
// ----------------------------------------------------------------------------
// Phase advance divider
// Radix-2 restoring divider for (num * 2^24) / den, truncated and saturated.
// ----------------------------------------------------------------------------
module pcpn_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo
);

    localparam int DIVB = 56;

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [31:0]       r_rem;
    logic [DIVB-1:0]   r_num;
    logic [DIVB-1:0]   r_q;
    logic [31:0]       r_dm;
    logic              r_neg;
    logic              r_zero;

    logic [31:0] w_nm;
    logic [31:0] w_dm;
    logic [32:0] w_trial;
    logic        w_ge;

    assign w_nm    = i_num[31] ? (~i_num + 32'd1) : i_num;
    assign w_dm    = i_den[31] ? (~i_den + 32'd1) : i_den;
    assign w_trial = {r_rem, r_num[DIVB-1]};
    assign w_ge    = w_trial >= {1'b0, r_dm};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_num  <= {w_nm, 24'd0};
                r_dm   <= w_dm;
                r_neg  <= i_num[31] ^ i_den[31];
                r_zero <= (i_den == 32'sd0);
            end else if (r_busy) begin
                r_rem <= w_ge ? 32'(w_trial - {1'b0, r_dm}) : w_trial[31:0];
                r_num <= {r_num[DIVB-2:0], 1'b0};
                r_q   <= {r_q[DIVB-2:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DIVB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            o_quo = (r_q > 56'd2147483648) ? 32'sh80000000 : -$signed(r_q[31:0]);
        end else begin
            o_quo = (r_q > 56'd2147483647) ? 32'sh7fffffff : $signed(r_q[31:0]);
        end
    end

    assign o_done = r_done;

`ifndef NO_ASSERTIONS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider did not start");
`endif

endmodule

[hw/rtl/pcpn_ctrl.sv]
// ----------------------------------------------------------------------------
// Network step controller
// Sequences loads, read-back and the passes of one network step.
// ----------------------------------------------------------------------------
module pcpn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pcpn_pkg::t_dp_sts i_sts,
    output logic              o_ready,
    output pcpn_pkg::t_dp_cmd o_cmd
);
    import pcpn_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_RD_LAT, ST_RD_OUT, ST_F1Z_RD, ST_F1Z_LAT,
        ST_T_RD, ST_T_MUL, ST_T_CMP, ST_U_RD, ST_U_LAT, ST_U_FIRER, ST_U_DIV,
        ST_U_P, ST_I_X, ST_I_LO, ST_I_HI, ST_I_MUL, ST_I_V, ST_I_K,
        ST_I_APPLY, ST_U_NEXT, ST_O_SCAN
    } t_state;

    t_state r_state;
    logic   r_pass;
    logic   r_crv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
            r_crv   <= CRV_F1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) r_state <= ST_DECODE;
                end
                ST_DECODE: begin
                    priority if (i_sts.op == OP_STEP) begin
                        r_state <= ST_F1Z_RD;
                    end else if (i_sts.op == OP_READ) begin
                        r_state <= ST_RD_LAT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD_LAT: r_state <= ST_RD_OUT;
                ST_RD_OUT: begin
                    if (i_sts.out_free) r_state <= ST_IDLE;
                end
                ST_F1Z_RD: begin
                    r_pass  <= 1'b0;
                    r_state <= ST_F1Z_LAT;
                end
                ST_F1Z_LAT: r_state <= ST_T_RD;
                ST_T_RD:    r_state <= ST_T_MUL;
                ST_T_MUL:   r_state <= ST_T_CMP;
                ST_T_CMP: begin
                    priority if (!i_sts.n_last) begin
                        r_state <= ST_T_RD;
                    end else if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_state <= ST_T_RD;
                    end else begin
                        r_state <= ST_U_RD;
                    end
                end
                ST_U_RD:  r_state <= ST_U_LAT;
                ST_U_LAT: r_state <= i_sts.fire_n ? ST_U_FIRER : ST_U_DIV;
                ST_U_FIRER: r_state <= ST_U_NEXT;
                ST_U_DIV: begin
                    if (i_sts.div_done) r_state <= ST_U_P;
                end
                ST_U_P: begin
                    r_crv   <= CRV_F2;
                    r_state <= ST_I_X;
                end
                ST_I_X:   r_state <= ST_I_LO;
                ST_I_LO:  r_state <= ST_I_HI;
                ST_I_HI:  r_state <= ST_I_MUL;
                ST_I_MUL: r_state <= ST_I_V;
                ST_I_V:   r_state <= ST_I_K;
                ST_I_K:   r_state <= ST_I_APPLY;
                ST_I_APPLY: begin
                    if (r_crv == CRV_F2) begin
                        r_crv   <= CRV_F1;
                        r_state <= ST_I_X;
                    end else begin
                        r_state <= ST_U_NEXT;
                    end
                end
                ST_U_NEXT: r_state <= i_sts.n_last ? ST_O_SCAN : ST_U_RD;
                ST_O_SCAN: begin
                    if (i_sts.n_last && (!i_sts.fire_n || i_sts.out_free)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.crv = r_crv;
        unique case (r_state)
            ST_IDLE:    o_cmd.op = i_valid ? DP_CAPTURE : DP_NOP;
            ST_DECODE:  o_cmd.op = DP_DECODE;
            ST_RD_LAT:  o_cmd.op = DP_RD_LAT;
            ST_RD_OUT:  o_cmd.op = DP_RD_OUT;
            ST_F1Z_RD:  o_cmd.op = DP_F1Z_RD;
            ST_F1Z_LAT: o_cmd.op = DP_F1Z_LAT;
            ST_T_RD:    o_cmd.op = DP_T_RD;
            ST_T_MUL:   o_cmd.op = DP_T_MUL;
            ST_T_CMP:   o_cmd.op = r_pass ? DP_T_FIRE : DP_T_MIN;
            ST_U_RD:    o_cmd.op = DP_U_RD;
            ST_U_LAT:   o_cmd.op = DP_U_LAT;
            ST_U_FIRER: o_cmd.op = DP_U_FIRER;
            ST_U_DIV:   o_cmd.op = DP_NOP;
            ST_U_P:     o_cmd.op = DP_U_P;
            ST_I_X:     o_cmd.op = DP_I_X;
            ST_I_LO:    o_cmd.op = DP_I_LO;
            ST_I_HI:    o_cmd.op = DP_I_HI;
            ST_I_MUL:   o_cmd.op = DP_I_MUL;
            ST_I_V:     o_cmd.op = DP_I_V;
            ST_I_K:     o_cmd.op = DP_I_K;
            ST_I_APPLY: o_cmd.op = DP_I_APPLY;
            ST_U_NEXT:  o_cmd.op = DP_U_NEXT;
            ST_O_SCAN:  o_cmd.op = DP_O_SCAN;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

    assign o_ready = (r_state == ST_IDLE);

`ifndef NO_ASSERTIONS
    a_adv_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_P) |-> ($past(r_state == ST_U_DIV) && $past(i_sts.div_done)))
        else $error("phase advance used before division finished");
`endif

endmodule

[hw/rtl/pcpn_dp.sv]
// ----------------------------------------------------------------------------
// Network step datapath
// Curve and neuron memories, arithmetic registers and the result register.
// ----------------------------------------------------------------------------
module pcpn_dp #(
    parameter int NEURONS     = 2,
    parameter int CURVE_STEPS = 100
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcpn_pkg::t_dp_cmd i_cmd,
    output pcpn_pkg::t_dp_sts o_sts,
    input  logic [111:0]      i_s_tdata,
    input  logic [2:0]        i_s_tuser,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [103:0]      o_m_tdata,
    output logic [0:0]        o_m_tuser,
    output logic              o_m_tlast
);
    import pcpn_pkg::*;

    localparam int NAW = $clog2(NEURONS);
    localparam int CAW = $clog2(CURVE_STEPS + 1);
    localparam int CNW = $clog2(NEURONS + 1);
    localparam logic [9:0] CS10 = 10'(CURVE_STEPS);
    localparam logic [9:0] N10  = 10'(NEURONS);
    localparam logic [CAW-1:0] CSA = CAW'(CURVE_STEPS);
    localparam logic [NAW-1:0] NLAST = NAW'(NEURONS - 1);
    localparam logic signed [43:0] CSX = 44'(CURVE_STEPS);

    logic [2:0]          r_op;
    logic [9:0]          r_idx;
    logic signed [31:0]  r_wa, r_wb, r_wc;
    logic signed [31:0]  r_f1z, r_tmin;
    logic signed [64:0]  r_tp;
    logic [NAW-1:0]      r_n;
    logic [CNW-1:0]      r_count, r_k;
    logic [NEURONS-1:0]  r_fire;
    logic signed [31:0]  r_ph, r_pend, r_p;
    logic signed [43:0]  r_x;
    logic [CAW-1:0]      r_m;
    logic signed [24:0]  r_r;
    logic                r_oor;
    logic signed [31:0]  r_lo;
    logic signed [57:0]  r_vp;
    logic signed [34:0]  r_v;
    logic signed [43:0]  r_kv;

    logic                r_ovalid, r_okind, r_olast;
    logic [5:0]          r_oneu;
    logic signed [31:0]  r_oint, r_oph, r_opend;

    logic                w_out_free, w_n_last, w_crv_ok, w_neu_ok;
    logic [NAW-1:0]      w_naddr;
    logic [CAW-1:0]      w_caddr;
    logic                w_f1_we, w_f2_we, w_per_we, w_ph_we, w_pend_we;
    logic signed [31:0]  w_ph_wd, w_pend_wd;
    logic [31:0]         w_f1_rd, w_f2_rd, w_per_rd, w_ph_rd, w_pend_rd;
    logic signed [31:0]  w_t, w_adv, w_hi, w_firph, w_newph;
    logic signed [32:0]  w_diff;
    logic                w_xneg, w_oor;
    logic [19:0]         w_mpos;
    logic [CAW-1:0]      w_m;
    logic signed [24:0]  w_r;
    logic                w_div_done, w_div_start;

    function automatic logic signed [31:0] crv_val(input logic crv,
                                                   input logic [CAW-1:0] i,
                                                   input logic [31:0] d1,
                                                   input logic [31:0] d2,
                                                   input logic signed [31:0] f1z);
        logic signed [31:0] v;
        if (crv == CRV_F1) begin
            v = (i == CSA) ? 32'sd0 : $signed(d1);
        end else if (i == '0) begin
            v = 32'sd0;
        end else if (i == CSA) begin
            v = f1z;
        end else begin
            v = $signed(d2);
        end
        return v;
    endfunction

    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_n_last   = (r_n == NLAST);
    assign w_crv_ok   = (r_idx <= CS10);
    assign w_neu_ok   = (r_idx < N10);

    assign o_sts.op       = r_op;
    assign o_sts.out_free = w_out_free;
    assign o_sts.n_last   = w_n_last;
    assign o_sts.fire_n   = r_fire[r_n];
    assign o_sts.div_done = w_div_done;

    assign w_naddr = (i_cmd.op == DP_DECODE) ? r_idx[NAW-1:0] : r_n;

    always_comb begin
        unique case (i_cmd.op)
            DP_DECODE: w_caddr = r_idx[CAW-1:0];
            DP_I_LO:   w_caddr = w_m;
            DP_I_HI:   w_caddr = r_m + CAW'(1);
            default:   w_caddr = '0;
        endcase
    end

    assign w_xneg = r_x[43];
    assign w_mpos = r_x[43:24];
    assign w_oor  = w_xneg ? (r_x <= -44'sd16777216) : (w_mpos >= 20'(CURVE_STEPS));
    assign w_m    = (w_oor || w_xneg) ? '0 : w_mpos[CAW-1:0];
    assign w_r    = w_xneg ? r_x[24:0] : $signed({1'b0, r_x[23:0]});

    assign w_t     = sat32(72'(r_tp >>> 24));
    assign w_hi    = crv_val(i_cmd.crv, r_m + CAW'(1), w_f1_rd, w_f2_rd, r_f1z);
    assign w_diff  = 33'(w_hi) - 33'(r_lo);
    assign w_firph = sat32(-72'(r_pend)
                     - (72'($signed({1'b0, r_count})) - 72'sd1) * 72'(r_f1z));
    assign w_newph = sat32(72'(r_p) - 72'(r_kv));

    assign w_f1_we  = (i_cmd.op == DP_DECODE) && (r_op == OP_LOAD_F1) && w_crv_ok;
    assign w_f2_we  = (i_cmd.op == DP_DECODE) && (r_op == OP_LOAD_F2) && w_crv_ok;
    assign w_per_we = (i_cmd.op == DP_DECODE) && (r_op == OP_LOAD_N) && w_neu_ok;
    assign w_ph_we  = w_per_we || (i_cmd.op == DP_U_FIRER)
                      || ((i_cmd.op == DP_I_APPLY) && (i_cmd.crv == CRV_F1));
    assign w_pend_we = w_ph_we;

    always_comb begin
        unique case (i_cmd.op)
            DP_U_FIRER: begin
                w_ph_wd   = w_firph;
                w_pend_wd = 32'sd0;
            end
            DP_I_APPLY: begin
                w_ph_wd   = w_newph;
                w_pend_wd = r_pend;
            end
            default: begin
                w_ph_wd   = r_wb;
                w_pend_wd = r_wc;
            end
        endcase
    end

    assign w_div_start = (i_cmd.op == DP_U_LAT) && !r_fire[r_n];

    pcpn_ram #(.WIDTH(32), .DEPTH(CURVE_STEPS + 1)) u_f1_ram (
        .i_clk(i_clk), .i_we(w_f1_we), .i_waddr(r_idx[CAW-1:0]), .i_wdata(r_wa),
        .i_raddr(w_caddr), .o_rdata(w_f1_rd));

    pcpn_ram #(.WIDTH(32), .DEPTH(CURVE_STEPS + 1)) u_f2_ram (
        .i_clk(i_clk), .i_we(w_f2_we), .i_waddr(r_idx[CAW-1:0]), .i_wdata(r_wa),
        .i_raddr(w_caddr), .o_rdata(w_f2_rd));

    pcpn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_per_ram (
        .i_clk(i_clk), .i_we(w_per_we), .i_waddr(w_naddr), .i_wdata(r_wa),
        .i_raddr(w_naddr), .o_rdata(w_per_rd));

    pcpn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_ph_ram (
        .i_clk(i_clk), .i_we(w_ph_we), .i_waddr(w_naddr), .i_wdata(w_ph_wd),
        .i_raddr(w_naddr), .o_rdata(w_ph_rd));

    pcpn_ram #(.WIDTH(32), .DEPTH(NEURONS)) u_pend_ram (
        .i_clk(i_clk), .i_we(w_pend_we), .i_waddr(w_naddr), .i_wdata(w_pend_wd),
        .i_raddr(w_naddr), .o_rdata(w_pend_rd));

    pcpn_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_tmin), .i_den($signed(w_per_rd)),
        .o_done(w_div_done), .o_quo(w_adv));

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_CAPTURE: begin
                r_op  <= i_s_tuser;
                r_idx <= i_s_tdata[9:0];
                r_wa  <= $signed(i_s_tdata[41:10]);
                r_wb  <= $signed(i_s_tdata[73:42]);
                r_wc  <= $signed(i_s_tdata[105:74]);
            end
            DP_RD_LAT: begin
                r_ph   <= w_neu_ok ? $signed(w_ph_rd) : 32'sd0;
                r_pend <= w_neu_ok ? $signed(w_pend_rd) : 32'sd0;
            end
            DP_F1Z_RD: begin
                r_n     <= '0;
                r_count <= '0;
                r_k     <= '0;
            end
            DP_F1Z_LAT: r_f1z <= $signed(w_f1_rd);
            DP_T_MUL: begin
                r_tp <= 65'($signed(w_per_rd))
                        * 65'(33'sd16777216 - 33'($signed(w_ph_rd)));
            end
            DP_T_MIN: begin
                if ((r_n == '0) || (w_t < r_tmin)) r_tmin <= w_t;
                r_n <= w_n_last ? '0 : r_n + NAW'(1);
            end
            DP_T_FIRE: begin
                r_fire[r_n] <= (w_t == r_tmin);
                if (w_t == r_tmin) r_count <= r_count + CNW'(1);
                r_n <= w_n_last ? '0 : r_n + NAW'(1);
            end
            DP_U_LAT: begin
                r_ph   <= $signed(w_ph_rd);
                r_pend <= $signed(w_pend_rd);
            end
            DP_U_P:  r_p <= sat32(72'(r_ph) + 72'(w_adv));
            DP_I_X:  r_x <= 44'(r_p) * CSX;
            DP_I_LO: begin
                r_m   <= w_m;
                r_r   <= w_r;
                r_oor <= w_oor;
            end
            DP_I_HI:  r_lo <= crv_val(i_cmd.crv, r_m, w_f1_rd, w_f2_rd, r_f1z);
            DP_I_MUL: r_vp <= 58'(r_r) * 58'(w_diff);
            DP_I_V: begin
                if (r_oor) begin
                    r_v <= (i_cmd.crv == CRV_F1) ? 35'(r_f1z) : 35'sd0;
                end else begin
                    r_v <= 35'(r_lo) + 35'(r_vp >>> 24);
                end
            end
            DP_I_K: r_kv <= 44'($signed({1'b0, r_count})) * 44'(r_v);
            DP_I_APPLY: begin
                if (i_cmd.crv == CRV_F2) r_pend <= sat32(72'(r_pend) + 72'(r_kv));
            end
            DP_U_NEXT: r_n <= w_n_last ? '0 : r_n + NAW'(1);
            DP_O_SCAN: begin
                if (!r_fire[r_n] || w_out_free) begin
                    r_n <= w_n_last ? '0 : r_n + NAW'(1);
                    if (r_fire[r_n]) r_k <= r_k + CNW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((i_cmd.op == DP_RD_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if ((i_cmd.op == DP_O_SCAN) && r_fire[r_n] && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == DP_RD_OUT) && w_out_free) begin
            r_okind <= KIND_READ;
            r_oneu  <= r_idx[5:0];
            r_oint  <= 32'sd0;
            r_oph   <= r_ph;
            r_opend <= r_pend;
            r_olast <= 1'b1;
        end else if ((i_cmd.op == DP_O_SCAN) && r_fire[r_n] && w_out_free) begin
            r_okind <= KIND_SPIKE;
            r_oneu  <= 6'(r_n);
            r_oint  <= (r_k == '0) ? r_tmin : 32'sd0;
            r_oph   <= 32'sd0;
            r_opend <= 32'sd0;
            r_olast <= ((r_k + CNW'(1)) == r_count);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_opend, r_oph, r_oint, r_oneu};
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_m_tready) |=>
            (r_ovalid && $stable({r_okind, r_oneu, r_oint, r_oph, r_opend, r_olast})))
        else $error("result beat changed while stalled");
`endif

endmodule

[hw/rtl/pulse_coupled_phase_network_step_unit.sv]
// ----------------------------------------------------------------------------
// Pulse-coupled phase network step unit
// Event-driven all-to-all phase oscillator network with tabulated responses.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the slave stream (opcode in tuser) and results
// leave as beats on the master stream (kind in tuser, tlast on the final
// result of a command). One command is worked on at a time; the input is
// ready only while the unit is idle, and a finished result may still wait in
// the output register while the next command is taken.
// A step makes two timing passes over the neurons, then updates each neuron
// in turn; for each non-firing neuron the radix-2 divider forms the phase
// advance, followed by two table interpolations on shared units. Last, the
// unit emits one spike beat per firing neuron.
// Reset returns the controller to idle and empties the output register; the
// table and neuron memories keep no reset value and must be loaded before
// a step or read-back uses them. When the receiver stalls, the current
// result holds on the master port and the unit waits before producing the
// next one; nothing is dropped.
// ----------------------------------------------------------------------------
module pulse_coupled_phase_network_step_unit #(
    parameter int NEURONS     = 2,
    parameter int CURVE_STEPS = 100
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [111:0] i_s_tdata,  // index[9:0], word_a, word_b, word_c, zero pad
    input  logic [2:0]   i_s_tuser,  // op
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [103:0] o_m_tdata,  // neuron[5:0], interval, phase, pending_sum, pad
    output logic [0:0]   o_m_tuser,  // kind
    output logic         o_m_tlast
);
    import pcpn_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pcpn_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_s_tvalid),
        .i_sts(w_sts), .o_ready(o_s_tready), .o_cmd(w_cmd));

    pcpn_dp #(.NEURONS(NEURONS), .CURVE_STEPS(CURVE_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast));

endmodule
